### rtl/core/f2d_pkg.sv
// Shared types, command/status structs and constants for the float-to-decimal text block.
// Depends on nothing; every other file of the block imports it.
package f2d_pkg;

    localparam int MantW   = 24;
    localparam int ExpW    = 10;
    localparam int KW      = 5;
    localparam int PosW    = 5;
    localparam int NumDig  = 19;
    localparam int BcdW    = 4 * NumDig;
    localparam int PowN    = 19;
    localparam int WholeW  = 64;
    localparam int ProdW   = 2 * MantW;
    localparam int BcdCycW = 5;

    // exponent of the unbiased mantissa form (value = mant * 2^exp)
    localparam logic signed [ExpW-1:0] ExpBias  = 10'sd150;
    localparam logic signed [ExpW-1:0] ExpOvf   = 10'sd40;
    localparam logic [BcdCycW-1:0]     BcdLastCyc = 5'd31;

    localparam logic [7:0] ChrMinus = 8'h2D;
    localparam logic [7:0] ChrDot   = 8'h2E;
    localparam logic [7:0] ChrZero  = 8'h30;
    localparam logic [7:0] ChrNone  = 8'h00;

    // character kinds
    localparam logic [1:0] CH_MINUS = 2'd0;
    localparam logic [1:0] CH_DIGIT = 2'd1;
    localparam logic [1:0] CH_DOT   = 2'd2;
    localparam logic [1:0] CH_FLAG  = 2'd3;

    typedef logic signed [ExpW-1:0] t_exp;

    typedef struct packed {
        logic [MantW-1:0] mant;
        t_exp             expo;
    } t_pflt;

    typedef struct packed {
        logic            load;
        logic            mul;
        logic            rnd;
        logic            bcd_load;
        logic            bcd_step;
        logic            emit;
        logic [1:0]      ch_sel;
        logic            ch_last;
        logic [PosW-1:0] pos;
        logic [KW-1:0]   k;
    } t_cmd;

    typedef struct packed {
        logic            is_nan;
        logic            is_zero;
        logic            is_sub;
        logic            neg;
        logic            ovf;
        logic            frac;
        logic [PosW-1:0] nd;
        logic            out_busy;
    } t_sts;

    // single-precision value of 10^idx, rounded to nearest even, as mantissa and exponent
    function automatic t_pflt pow_float(input int idx);
        logic [63:0] v;
        logic [63:0] r;
        logic        g;
        logic        s;
        int          n;
        int          sh;
        t_pflt       pf;
        v = 64'd1;
        for (int i = 0; i < idx; i++) v = v * 64'd10;
        n = 0;
        for (int i = 0; i < 64; i++) if (v[i]) n = i;
        if (n <= 23) begin
            r = v << (23 - n);
            pf.mant = r[MantW-1:0];
            pf.expo = ExpW'(n - 23);
        end else begin
            sh = n - 23;
            r = v >> sh;
            g = v[sh-1];
            s = |(v & ((64'd1 << (sh - 1)) - 64'd1));
            if (g & (s | r[0])) r = r + 64'd1;
            if (r[MantW]) begin
                r = r >> 1;
                sh = sh + 1;
            end
            pf.mant = r[MantW-1:0];
            pf.expo = ExpW'(sh);
        end
        return pf;
    endfunction

endpackage

### rtl/core/f2d_dp.sv
// Datapath: input capture, float scaling multiply and rounding, binary-to-BCD
// conversion and the output register. Depends on f2d_pkg; driven by f2d_ctrl.
module f2d_dp import f2d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_bits,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast,
    output logic [0:0]  o_m_tuser
);

    logic [31:0]       r_bits;
    logic [MantW-1:0]  r_mm;
    t_exp              r_me;
    logic [MantW-1:0]  r_m;
    t_exp              r_e;
    logic [ProdW-1:0]  r_prod;
    t_exp              r_pe;
    logic [WholeW-1:0] r_bin;
    logic [BcdW-1:0]   r_bcd;
    logic              r_ov;
    logic [7:0]        r_od;
    logic              r_ol;
    logic              r_ou;

    t_pflt             w_pow [PowN];
    logic [WholeW-1:0] w_whole;
    logic              w_frac;
    t_exp              w_nsh;
    logic [MantW-1:0]  w_keep;
    logic              w_g;
    logic              w_s;
    logic              w_up;
    logic [MantW:0]    w_sum;
    t_exp              w_re;
    logic [BcdW-1:0]   w_bcd_n;
    logic [WholeW-1:0] w_bin_n;
    logic [3:0]        w_dig [NumDig];
    logic [PosW-1:0]   w_nd;
    logic [7:0]        w_ch;
    logic [7:0]        w_expf;

    for (genvar g = 0; g < PowN; g++) begin : g_pow
        assign w_pow[g] = pow_float(g);
    end

    assign w_expf = i_bits[30:23];

    // whole part and fraction test of r_m * 2^r_e
    assign w_nsh = -r_e;
    always_comb begin
        w_whole = '0;
        w_frac  = 1'b0;
        if (!r_e[ExpW-1]) begin
            w_whole = {{(WholeW-MantW){1'b0}}, r_m} << r_e[5:0];
        end else if (w_nsh >= 10'sd24) begin
            w_frac = (r_m != '0);
        end else begin
            w_whole = {{(WholeW-MantW){1'b0}}, r_m >> w_nsh[4:0]};
            w_frac  = ((r_m & ((24'd1 << w_nsh[4:0]) - 24'd1)) != '0);
        end
    end

    // round product to nearest even
    always_comb begin
        if (r_prod[ProdW-1]) begin
            w_keep = r_prod[47:24];
            w_g    = r_prod[23];
            w_s    = |r_prod[22:0];
            w_re   = r_pe + 10'sd24;
        end else begin
            w_keep = r_prod[46:23];
            w_g    = r_prod[22];
            w_s    = |r_prod[21:0];
            w_re   = r_pe + 10'sd23;
        end
        w_up  = w_g & (w_s | w_keep[0]);
        w_sum = {1'b0, w_keep} + {{MantW{1'b0}}, w_up};
    end

    // two double-dabble steps per cycle
    always_comb begin
        w_bcd_n = r_bcd;
        w_bin_n = r_bin;
        for (int s = 0; s < 2; s++) begin
            for (int d = 0; d < NumDig; d++) begin
                if (w_bcd_n[4*d +: 4] >= 4'd5) w_bcd_n[4*d +: 4] = w_bcd_n[4*d +: 4] + 4'd3;
            end
            w_bcd_n = {w_bcd_n[BcdW-2:0], w_bin_n[WholeW-1]};
            w_bin_n = {w_bin_n[WholeW-2:0], 1'b0};
        end
    end

    always_comb begin
        w_nd = PosW'(1);
        for (int d = 0; d < NumDig; d++) begin
            w_dig[d] = r_bcd[4*d +: 4];
            if (r_bcd[4*d +: 4] != 4'd0) w_nd = PosW'(d + 1);
        end
    end

    always_comb begin
        case (i_cmd.ch_sel)
            CH_MINUS: w_ch = ChrMinus;
            CH_DOT:   w_ch = ChrDot;
            CH_DIGIT: w_ch = ChrZero + {4'd0, w_dig[i_cmd.pos]};
            default:  w_ch = ChrNone;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bits <= i_bits;
            r_mm   <= (w_expf == 8'd0) ? '0 : {1'b1, i_bits[22:0]};
            r_me   <= $signed({2'b00, w_expf}) - ExpBias;
            r_m    <= (w_expf == 8'd0) ? '0 : {1'b1, i_bits[22:0]};
            r_e    <= $signed({2'b00, w_expf}) - ExpBias;
        end
        if (i_cmd.mul) begin
            r_prod <= r_mm * w_pow[i_cmd.k].mant;
            r_pe   <= r_me + w_pow[i_cmd.k].expo;
        end
        if (i_cmd.rnd) begin
            if (w_sum[MantW]) begin
                r_m <= {1'b1, {(MantW-1){1'b0}}};
                r_e <= w_re + 10'sd1;
            end else begin
                r_m <= w_sum[MantW-1:0];
                r_e <= w_re;
            end
        end
        if (i_cmd.bcd_load) begin
            r_bin <= w_whole;
            r_bcd <= '0;
        end else if (i_cmd.bcd_step) begin
            r_bin <= w_bin_n;
            r_bcd <= w_bcd_n;
        end
        if (i_cmd.emit) begin
            r_od <= w_ch;
            r_ol <= i_cmd.ch_last;
            r_ou <= (i_cmd.ch_sel == CH_FLAG);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_sts.is_nan   = (r_bits[30:23] == 8'hFF);
    assign o_sts.is_zero  = (r_bits[30:23] == 8'd0) && (r_bits[22:0] == '0);
    assign o_sts.is_sub   = (r_bits[30:23] == 8'd0) && (r_bits[22:0] != '0);
    assign o_sts.neg      = r_bits[31] && (r_bits[30:0] != '0);
    assign o_sts.ovf      = (r_e >= ExpOvf);
    assign o_sts.frac     = w_frac;
    assign o_sts.nd       = w_nd;
    assign o_sts.out_busy = r_ov & ~i_m_tready;

    assign o_m_tvalid   = r_ov;
    assign o_m_tdata    = r_od;
    assign o_m_tlast    = r_ol;
    assign o_m_tuser[0] = r_ou;

endmodule

### rtl/core/f2d_ctrl.sv
// Controller: sequences classification, the place search, BCD conversion and
// character emission. Depends on f2d_pkg; commands f2d_dp.
module f2d_ctrl import f2d_pkg::*; #(
    parameter int MAX_PLACES = 9
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic [3:0] i_places,
    input  t_sts       i_sts,
    output logic       o_s_tready,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLASS = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_RND   = 4'd4;
    localparam logic [3:0] S_BCD   = 4'd5;
    localparam logic [3:0] S_SIGN  = 4'd6;
    localparam logic [3:0] S_DIG   = 4'd7;
    localparam logic [3:0] S_DOTE  = 4'd8;
    localparam logic [3:0] S_FLAG  = 4'd9;

    logic [3:0]         r_state, n_state;
    logic [KW-1:0]      r_k, n_k;
    logic [KW-1:0]      r_lim, n_lim;
    logic [BcdCycW-1:0] r_cnt, n_cnt;
    logic [PosW-1:0]    r_pos, n_pos;
    logic               r_dot, n_dot;
    logic [PosW-1:0]    w_ndig;
    logic [KW-1:0]      w_places;

    assign w_places = {1'b0, i_places};
    assign w_ndig   = (i_sts.nd > (r_k + KW'(1))) ? i_sts.nd : (r_k + KW'(1));

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_lim   = r_lim;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_dot   = r_dot;
        o_s_tready = 1'b0;
        o_cmd         = '0;
        o_cmd.k       = r_k;
        o_cmd.pos     = r_pos;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_k   = '0;
                    n_lim = (w_places > KW'(MAX_PLACES)) ? KW'(MAX_PLACES) : w_places;
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                n_cnt = '0;
                if (i_sts.is_nan) begin
                    n_state = S_FLAG;
                end else if (i_sts.is_zero) begin
                    o_cmd.bcd_load = 1'b1;
                    n_state = S_BCD;
                end else if (i_sts.is_sub) begin
                    // tiny values never reach one: run straight to the place limit
                    n_k = r_lim;
                    o_cmd.bcd_load = 1'b1;
                    n_state = S_BCD;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_cnt = '0;
                if (i_sts.ovf) begin
                    n_state = S_FLAG;
                end else if (i_sts.frac && (r_k < r_lim)) begin
                    n_k = r_k + KW'(1);
                    n_state = S_MUL;
                end else begin
                    o_cmd.bcd_load = 1'b1;
                    n_state = S_BCD;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state = S_CHK;
            end
            S_BCD: begin
                o_cmd.bcd_step = 1'b1;
                n_cnt = r_cnt + BcdCycW'(1);
                if (r_cnt == BcdLastCyc) n_state = S_SIGN;
            end
            S_SIGN: begin
                n_pos = w_ndig - PosW'(1);
                n_dot = 1'b0;
                if (!i_sts.neg) begin
                    n_state = S_DIG;
                end else if (!i_sts.out_busy) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.ch_sel = CH_MINUS;
                    n_state = S_DIG;
                end
            end
            S_DIG: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    if ((r_k != '0) && (r_pos == (r_k - KW'(1))) && !r_dot) begin
                        o_cmd.ch_sel = CH_DOT;
                        n_dot = 1'b1;
                    end else begin
                        o_cmd.ch_sel  = CH_DIGIT;
                        o_cmd.ch_last = (r_pos == '0) && (r_k != '0);
                        if (r_pos == '0) begin
                            n_state = (r_k == '0) ? S_DOTE : S_IDLE;
                        end else begin
                            n_pos = r_pos - PosW'(1);
                        end
                    end
                end
            end
            S_DOTE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.ch_sel  = CH_DOT;
                    o_cmd.ch_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FLAG: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.ch_sel  = CH_FLAG;
                    o_cmd.ch_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_lim   <= '0;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_dot   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_lim   <= n_lim;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            r_dot   <= n_dot;
        end
    end

endmodule

### rtl/core/float_to_decimal_ascii.sv
// Float-to-decimal text converter: one single-precision value in, its decimal text out
// one ASCII character per transaction. Order of work: classify, then a check plus a
// multiply, round and check for each fraction place searched, BCD conversion, a sign step
// (it also emits any '-'), then the other characters one at a time; zero and subnormal
// values skip the check and the place search; NaN, Inf and overflow emit a flag character.
// One value in flight; the next input is accepted the cycle after the last character loads.
// Reset (i_rst_n low, synchronous) idles the controller and empties the output register.
module float_to_decimal_ascii import f2d_pkg::*; #(
    parameter int MAX_PLACES = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [31:0] float_bits, [35:32] frac_places, [39:36] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] character
    output logic        o_m_tlast,
    output logic [0:0]  o_m_tuser    // [0] out_of_range
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: place search, conversion and emission order
    f2d_ctrl #(
        .MAX_PLACES(MAX_PLACES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_places   (i_s_tdata[35:32]),
        .i_sts      (w_sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    // arithmetic and output register
    f2d_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bits     (i_s_tdata[31:0]),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

### test/float_to_decimal_ascii_tb.sv
// Self-checking bench for the float-to-decimal text block: drives random and corner
// values over the input stream, predicts every character and compares on the output.
// Depends on f2d_pkg and float_to_decimal_ascii.

module float_to_decimal_ascii_tb import f2d_pkg::*; ();

    typedef struct {
        logic [7:0] chr;
        logic       last;
        logic       oor;
    } t_char;

    class text_scoreboard;
        t_char pending_chars[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        // 24-bit significand times 2^exp, rounded to single precision after a scale by 10^k
        function void scale_round(input logic [23:0] m, input int e, input int k,
                                  output logic [24:0] sm, output int se);
            logic [63:0] prod;
            logic [63:0] r;
            int          n;
            int          sh;
            logic        g;
            logic        s;
            prod = 64'(m);
            for (int i = 0; i < k; i++) prod = prod * 64'd10;
            n = 0;
            for (int i = 0; i < 64; i++) if (prod[i]) n = i;
            if (n <= 23) begin
                sm = prod[24:0];
                se = e;
            end else begin
                sh = n - 23;
                r = prod >> sh;
                g = prod[sh-1];
                s = |(prod & ((64'd1 << (sh - 1)) - 64'd1));
                if (g & (s | r[0])) r = r + 64'd1;
                if (r[24]) begin
                    r = r >> 1;
                    sh = sh + 1;
                end
                sm = r[24:0];
                se = e + sh;
            end
        endfunction

        // true when sm * 2^se >= 2^63
        function bit too_big(input logic [24:0] sm, input int se);
            int n;
            if (sm == 0) return 0;
            n = 0;
            for (int i = 0; i < 25; i++) if (sm[i]) n = i;
            return (se + n) >= 63;
        endfunction

        function void split_whole(input logic [24:0] sm, input int se,
                                  output logic [63:0] whole, output bit frac);
            logic [63:0] mm;
            mm = 64'(sm);
            if (se >= 0) begin
                whole = mm << se;
                frac  = 0;
            end else if (-se >= 64) begin
                whole = 0;
                frac  = (sm != 0);
            end else begin
                whole = mm >> (-se);
                frac  = |(mm & ((64'd1 << (-se)) - 64'd1));
            end
        endfunction

        function void push_char(input logic [7:0] c, input logic l, input logic o);
            t_char t;
            t.chr = c;
            t.last = l;
            t.oor = o;
            pending_chars.push_back(t);
        endfunction

        // note an accepted value: work out its text and queue each character
        function void note_value(input logic [31:0] bits, input logic [3:0] places);
            int          lim;
            int          k;
            logic [23:0] m;
            int          e;
            logic [24:0] sm;
            int          se;
            logic [63:0] whole;
            logic [63:0] ip;
            logic [63:0] p10;
            bit          frac;
            bit          neg;
            int          idig;
            int          ndig;
            logic [7:0]  dig[20];
            t_char       t;
            lim = (places > 4'd9) ? 9 : int'(places);
            if (bits[30:23] == 8'hFF) begin
                push_char(ChrNone, 1'b1, 1'b1);
                return;
            end
            if (bits[30:23] == 8'd0) begin
                m = {1'b0, bits[22:0]};
                e = -149;
            end else begin
                m = {1'b1, bits[22:0]};
                e = int'(bits[30:23]) - 150;
            end
            // negative zero does not count as negative
            neg = bits[31] && (m != 0);
            k = 0;
            scale_round(m, e, 0, sm, se);
            if (too_big(sm, se)) begin
                push_char(ChrNone, 1'b1, 1'b1);
                return;
            end
            split_whole(sm, se, whole, frac);
            while (frac && k < lim) begin
                k++;
                scale_round(m, e, k, sm, se);
                if (too_big(sm, se)) begin
                    push_char(ChrNone, 1'b1, 1'b1);
                    return;
                end
                split_whole(sm, se, whole, frac);
            end
            p10 = 64'd1;
            for (int i = 0; i < k; i++) p10 = p10 * 64'd10;
            ip = whole / p10;
            idig = 1;
            while (ip >= 64'd10) begin
                ip = ip / 64'd10;
                idig++;
            end
            ndig = idig + k;
            for (int i = ndig; i > 0; i--) begin
                dig[i-1] = 8'(whole % 64'd10);
                whole = whole / 64'd10;
            end
            if (neg) push_char(ChrMinus, 1'b0, 1'b0);
            for (int i = 0; i < ndig; i++) begin
                if (i == idig) push_char(ChrDot, 1'b0, 1'b0);
                push_char(ChrZero + dig[i], 1'b0, 1'b0);
            end
            if (k == 0) push_char(ChrDot, 1'b0, 1'b0);
            t = pending_chars.pop_back();
            t.last = 1'b1;
            pending_chars.push_back(t);
        endfunction

        task report(input string what, input logic [7:0] got, input logic [7:0] want);
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        // check one accepted character against the oldest expectation
        task check_char(input logic [7:0] c, input logic l, input logic o);
            t_char t;
            if (pending_chars.size() == 0) begin
                report("unexpected character", c, 8'h00);
                return;
            end
            t = pending_chars.pop_front();
            if (c !== t.chr) report("character", c, t.chr);
            if (l !== t.last) report("last", 8'(l), 8'(t.last));
            if (o !== t.oor) report("out_of_range", 8'(o), 8'(t.oor));
        endtask
    endclass

    localparam int CycleLimit = 1000000;
    localparam int RandItems  = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // [31:0] float_bits, [35:32] frac_places, [39:36] zero
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // [7:0] character
    logic        o_m_tlast;
    logic [0:0]  o_m_tuser;   // [0] out_of_range

    text_scoreboard sb;
    int  cycles;
    int  hold_off;       // cycles left in the long receiver stall
    bit  hold_done;
    bit  burst_mode;     // stretch with the receiver always ready

    float_to_decimal_ascii dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(5, 40);
    endfunction

    // give up on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: check every accepted character, then pick the next tready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_char(o_m_tdata, o_m_tlast, o_m_tuser[0]);
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_off > 0) begin
            // long stall: let the block fill up and push back on its input
            hold_off <= hold_off - 1;
            i_m_tready <= 1'b0;
        end else if (burst_mode) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= (gap_len() == 0);
        end
    end

    // offer one value and hold it until the block takes the transaction
    task automatic send_value(input logic [31:0] bits, input logic [3:0] places);
        int g;
        g = burst_mode ? 0 : gap_len();
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, places, bits};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_value(bits, places);
    endtask

    // random value: mostly moderate exponents so the place search does real work
    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9)) inside
            [0:1]:   ;                                            // raw pattern
            2:       v[30:23] = 8'($urandom_range(180, 192));   // near the 2^63 limit
            3:       v[22:0] = v[22:0] & 23'h7FFF00;           // short mantissa
            default: v[30:23] = 8'($urandom_range(100, 150));
        endcase
        return v;
    endfunction

    initial begin
        sb = new();
        cycles = 0;
        hold_off = 0;
        hold_done = 0;
        burst_mode = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners: zeros, signs, NaN, infinities, the 2^63 limit, subnormals, saturation
        send_value(32'h0000_0000, 4'd3);
        send_value(32'h8000_0000, 4'd3);
        send_value(32'h3F80_0000, 4'd0);   // 1.0, no places
        send_value(32'hBFC0_0000, 4'd5);   // -1.5
        send_value(32'h3DCC_CCCD, 4'd9);   // 0.1
        send_value(32'h42F6_E979, 4'd3);   // 123.456
        send_value(32'h42F6_E979, 4'd0);
        send_value(32'h3DCC_CCCD, 4'd15);  // place count saturates
        send_value(32'h7FC0_0000, 4'd2);
        send_value(32'hFFFF_FFFF, 4'd2);
        send_value(32'h7F80_0000, 4'd2);
        send_value(32'hFF80_0000, 4'd2);
        send_value(32'h5F00_0000, 4'd1);   // exactly 2^63
        send_value(32'hDEFF_FFFF, 4'd1);   // just below 2^63, negative
        send_value(32'h0000_0001, 4'd9);   // smallest subnormal
        send_value(32'h807F_FFFF, 4'd9);
        send_value(32'h7F7F_FFFF, 4'd4);
        send_value(32'h4B7F_FFFF, 4'd8);   // 2^24 - 1, no fraction bit
        send_value(32'h3F7F_FFFF, 4'd9);
        send_value(32'h4E6E_6B28, 4'd9);   // 1e9

        for (int n = 0; n < RandItems; n++) begin
            if (n == 40 && !hold_done) begin
                // one long receiver stall while values keep coming
                hold_off = 400;
                hold_done = 1;
            end
            if (n % 50 == 25) burst_mode = ~burst_mode;
            send_value(rand_value(), 4'($urandom_range(0, 15)));
        end
        i_s_tvalid <= 1'b0;
        burst_mode = 0;

        while (sb.pending_chars.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/core/f2d_pkg.sv
rtl/core/f2d_dp.sv
rtl/core/f2d_ctrl.sv
rtl/core/float_to_decimal_ascii.sv
test/float_to_decimal_ascii_tb.sv
